// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/svlr_pkg.sv -----
// Package for the sample voice linear resampler: codes, widths, state type.
package svlr_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF        = 65536;
  localparam int unsigned SOURCE_CHANNELS_MAX_DEF = 2;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned POS_W  = 33;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned MIX_W  = 24;
  localparam int unsigned CFG_W  = 17;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] CFG_CROP_START = 2'd0;
  localparam logic [1:0] CFG_CROP_END   = 2'd1;
  localparam logic [1:0] CFG_SRC_CH     = 2'd2;

  localparam logic signed [MIX_W-1:0] MIX_MAX = 24'sh7FFFFF;
  localparam logic signed [MIX_W-1:0] MIX_MIN = -24'sh800000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } svlr_state_e;

endpackage

// ----- rtl/core/sample_voice_linear_resampler.sv -----
// Top level: one sampler voice with linear-interpolation resampling.
// A playing tick passes the states MUL1, MUL2 and FIN before its result is registered;
// other items go straight to FIN. No new item is taken until FIN hands a result on;
// a tick reaches FIN after the sample memory read and the two registered multiply steps.
// Reset clears position, step, gain, voice state, crop bounds, FSM state and output valid
// and sets the channel field to 1; sample memory is not cleared, undefined until loaded.
`include "assert_macros.svh"

module sample_voice_linear_resampler
  import svlr_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH        = SAMPLE_DEPTH_DEF,
  parameter int unsigned SOURCE_CHANNELS_MAX = SOURCE_CHANNELS_MAX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              in_operation_i,
  input  logic [15:0]             in_sample_address_i,
  input  logic                    in_sample_channel_i,
  input  logic signed [SMP_W-1:0] in_sample_value_i,
  input  logic [15:0]             in_note_velocity_i,
  input  logic [STEP_W-1:0]       in_step_ratio_i,
  input  logic [15:0]             in_envelope_level_i,
  input  logic                    in_envelope_active_i,
  input  logic signed [MIX_W-1:0] in_mix_in_left_i,
  input  logic signed [MIX_W-1:0] in_mix_in_right_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [MIX_W-1:0] out_mix_out_left_o,
  output logic signed [MIX_W-1:0] out_mix_out_right_o,
  output logic                    out_voice_playing_o,
  output logic                    out_note_ended_o
);

  localparam int unsigned AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned XW = (AW + 1 > 18) ? AW + 1 : 18;
  localparam int unsigned CH = SOURCE_CHANNELS_MAX;

  svlr_state_e state_q, state_d;

  logic [15:0]       crop_start_q;
  logic [16:0]       crop_end_q;
  logic [1:0]        src_ch_q;
  logic [POS_W-1:0]  pos_q;
  logic [STEP_W-1:0] step_q;
  logic [15:0]       gain_q;
  logic              voice_on_q;

  logic                    job_pass_q;
  logic                    job_play_q;
  logic                    job_end_q;
  logic signed [MIX_W-1:0] job_mix_q [2];
  logic [15:0]             frac_q;
  logic [16:0]             scale_q;
  logic                    ok0_q, ok1_q;

  logic [SMP_W-1:0]        rd_a_q [CH];
  logic [SMP_W-1:0]        rd_b_q [CH];
  logic signed [SMP_W-1:0] v1_q [2];
  logic signed [33:0]      p1_q [2];
  logic signed [34:0]      p2_q [2];

  logic                    out_valid_q;
  logic signed [MIX_W-1:0] out_l_q, out_r_q;
  logic                    out_play_q, out_end_q;

  logic in_fire, fin_fire, rd_en;

  // Accept-side decode
  logic [XW-1:0]     ld_addr, rd_idx0, rd_idx1;
  logic              ld_ok;
  logic [16:0]       ipos;
  logic              stop_hit;
  logic              tick_run;
  logic [33:0]       pos_sum;
  logic [POS_W-1:0]  pos_adv;
  logic [31:0]       scale_prod;
  logic              stereo;

  assign ld_addr    = XW'(in_sample_address_i);
  assign ld_ok      = ld_addr < XW'(SAMPLE_DEPTH);
  assign ipos       = pos_q[POS_W-1:16];
  assign rd_idx0    = XW'(ipos);
  assign rd_idx1    = rd_idx0 + XW'(1);
  assign stop_hit   = ({1'b0, ipos} + 18'd1 >= {1'b0, crop_end_q}) || !in_envelope_active_i;
  assign tick_run   = (in_operation_i == OP_TICK) && voice_on_q && !stop_hit;
  assign pos_sum    = {1'b0, pos_q} + 34'(step_q);
  assign pos_adv    = pos_sum[33] ? '1 : pos_sum[POS_W-1:0];
  assign scale_prod = 32'(in_envelope_level_i) * 32'(gain_q);
  assign stereo     = (CH > 1) && src_ch_q[1];

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = tick_run ? ST_MUL1 : ST_FIN;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    fin_fire   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_FIN:  fin_fire   = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_fire = in_valid_i && !in_stall_o;
  assign rd_en   = in_fire && (in_operation_i == OP_TICK);

  // Sample memories, one per channel
  for (genvar c = 0; c < CH; c++) begin : g_ch
    logic [SMP_W-1:0] sample_mem [SAMPLE_DEPTH];
    logic             wr_en;

    assign wr_en = in_fire && (in_operation_i == OP_LOAD) && ld_ok &&
                   (int'(in_sample_channel_i) == c);

    always_ff @(posedge clk_i) begin
      if (wr_en) sample_mem[ld_addr[AW-1:0]] <= in_sample_value_i;
      if (rd_en) begin
        rd_a_q[c] <= sample_mem[rd_idx0[AW-1:0]];
        rd_b_q[c] <= sample_mem[rd_idx1[AW-1:0]];
      end
    end
  end

  // Config and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crop_start_q <= '0;
      crop_end_q   <= '0;
      src_ch_q     <= 2'd1;
      pos_q        <= '0;
      step_q       <= '0;
      gain_q       <= '0;
      voice_on_q   <= 1'b0;
      state_q      <= ST_IDLE;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CROP_START: crop_start_q <= cfg_data_i[15:0];
          CFG_CROP_END:   crop_end_q   <= cfg_data_i[16:0];
          CFG_SRC_CH:     src_ch_q     <= cfg_data_i[1:0];
          default:        ;
        endcase
      end
      if (in_fire) begin
        case (in_operation_i)
          OP_START: begin
            voice_on_q <= 1'b1;
            pos_q      <= {1'b0, crop_start_q, 16'd0};
            step_q     <= in_step_ratio_i;
            gain_q     <= in_note_velocity_i;
          end
          OP_STOP: voice_on_q <= 1'b0;
          OP_TICK: begin
            if (voice_on_q) begin
              if (stop_hit) voice_on_q <= 1'b0;
              else          pos_q      <= pos_adv;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Transaction job registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_pass_q <= !tick_run;
      frac_q     <= pos_q[15:0];
      scale_q    <= scale_prod[31:15];
      ok0_q      <= rd_idx0 < XW'(SAMPLE_DEPTH);
      ok1_q      <= rd_idx1 < XW'(SAMPLE_DEPTH);
      if (in_operation_i == OP_TICK) begin
        job_mix_q[0] <= in_mix_in_left_i;
        job_mix_q[1] <= in_mix_in_right_i;
      end else begin
        job_mix_q[0] <= '0;
        job_mix_q[1] <= '0;
      end
      case (in_operation_i)
        OP_START: begin
          job_play_q <= 1'b1;
          job_end_q  <= 1'b0;
        end
        OP_STOP: begin
          job_play_q <= 1'b0;
          job_end_q  <= voice_on_q;
        end
        OP_TICK: begin
          job_play_q <= tick_run;
          job_end_q  <= voice_on_q && stop_hit;
        end
        default: begin
          job_play_q <= voice_on_q;
          job_end_q  <= 1'b0;
        end
      endcase
    end
  end

  // Interpolation datapath
  logic signed [SMP_W-1:0] v1_c [2];
  logic signed [SMP_W-1:0] v2_c [2];
  logic signed [16:0]      diff_c [2];
  logic signed [16:0]      interp_c [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (l == 1 && stereo) begin
        v1_c[l] = ok0_q ? $signed(rd_a_q[CH-1]) : '0;
        v2_c[l] = ok1_q ? $signed(rd_b_q[CH-1]) : '0;
      end else begin
        v1_c[l] = ok0_q ? $signed(rd_a_q[0]) : '0;
        v2_c[l] = ok1_q ? $signed(rd_b_q[0]) : '0;
      end
      diff_c[l]   = 17'(v2_c[l]) - 17'(v1_c[l]);
      interp_c[l] = 17'(v1_q[l]) + $signed(p1_q[l][32:16]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (state_q == ST_MUL1) begin
        v1_q[l] <= v1_c[l];
        p1_q[l] <= $signed({1'b0, frac_q}) * diff_c[l];
      end
      if (state_q == ST_MUL2) begin
        p2_q[l] <= interp_c[l] * $signed({1'b0, scale_q});
      end
    end
  end

  // Mix add with saturation
  logic signed [19:0]      contrib_c [2];
  logic signed [MIX_W:0]   sum_c [2];
  logic signed [MIX_W-1:0] sat_c [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      contrib_c[l] = job_pass_q ? '0 : p2_q[l][34:15];
      sum_c[l]     = {job_mix_q[l][MIX_W-1], job_mix_q[l]} + 25'(contrib_c[l]);
      if (sum_c[l][MIX_W] != sum_c[l][MIX_W-1]) begin
        sat_c[l] = sum_c[l][MIX_W] ? MIX_MIN : MIX_MAX;
      end else begin
        sat_c[l] = sum_c[l][MIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_l_q    <= sat_c[0];
      out_r_q    <= sat_c[1];
      out_play_q <= job_play_q;
      out_end_q  <= job_end_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_mix_out_left_o  = out_l_q;
  assign out_mix_out_right_o = out_r_q;
  assign out_voice_playing_o = out_play_q;
  assign out_note_ended_o    = out_end_q;

  `SVLR_ASSERT_NXT(a_busy_after_accept, in_fire, in_stall_o, "accepted item not held busy")
  `SVLR_ASSERT_IMP(a_end_not_playing, out_valid_o && out_note_ended_o, !out_voice_playing_o,
                   "voice ended but still playing")
  `SVLR_ASSERT_IMP(a_voice_off_cause, $fell(voice_on_q),
                   $past(in_fire) && ($past(in_operation_i) == OP_STOP ||
                   $past(in_operation_i) == OP_TICK), "voice stopped without stop or tick")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the sample voice linear resampler.
module tb
  import svlr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned STORE_DEPTH  = SAMPLE_DEPTH_DEF;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;

  typedef struct {
    logic [1:0]              op;
    logic [15:0]             addr;
    logic                    chan;
    logic signed [SMP_W-1:0] value;
    logic [15:0]             velocity;
    logic [STEP_W-1:0]       step;
    logic [15:0]             env_level;
    logic                    env_on;
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;
  } voice_item_t;

  typedef struct {
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;
    logic                    playing;
    logic                    ended;
  } mix_result_t;

  class voice_mix_scoreboard;
    shortint           sample_mem[int];
    bit [POS_W-1:0]    position;
    bit [STEP_W-1:0]   step_size;
    bit [15:0]         gain;
    bit                voice_on;
    bit [15:0]         crop_start;
    bit [16:0]         crop_end;
    bit [1:0]          channels;
    mix_result_t       expected_mix[$];
    int                errors;
    int                checked;
    int                voiced;
    int                note_ends;
    int                clamped;

    function new();
      position   = '0;
      step_size  = '0;
      gain       = '0;
      voice_on   = 1'b0;
      crop_start = '0;
      crop_end   = '0;
      channels   = 2'd1;
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch %0d: %s", errors, msg);
    endfunction

    function void note_config(logic [1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CROP_START: crop_start = data[15:0];
        CFG_CROP_END:   crop_end = data[16:0];
        CFG_SRC_CH:     channels = data[1:0];
        default: ;
      endcase
    endfunction

    function longint sample_at(bit chan, longint idx);
      int key;
      if (idx >= STORE_DEPTH) return 0;
      key = int'(chan) * STORE_DEPTH + int'(idx);
      if (sample_mem.exists(key)) return longint'(sample_mem[key]);
      return 0;
    endfunction

    function longint voice_part(bit chan, longint idx, longint frac, longint scale);
      longint v1, v2, interp;
      v1 = sample_at(chan, idx);
      v2 = sample_at(chan, idx + 1);
      interp = v1 + ((frac * (v2 - v1)) >>> 16);
      return (interp * scale) >>> 15;
    endfunction

    function logic signed [MIX_W-1:0] clamp_mix(longint v);
      if (v > longint'(MIX_MAX)) begin
        clamped++;
        return MIX_MAX;
      end
      if (v < longint'(MIX_MIN)) begin
        clamped++;
        return MIX_MIN;
      end
      return v[MIX_W-1:0];
    endfunction

    function mix_result_t predict_mix(voice_item_t it);
      mix_result_t r;
      longint      ipos, frac, scale, next_pos;
      r.mix_l = '0;
      r.mix_r = '0;
      r.ended = 1'b0;
      case (it.op)
        OP_LOAD: sample_mem[int'(it.chan) * STORE_DEPTH + int'(it.addr)] = it.value;
        OP_START: begin
          voice_on  = 1'b1;
          position  = {1'b0, crop_start, 16'h0000};
          step_size = it.step;
          gain      = it.velocity;
        end
        OP_STOP: begin
          r.ended  = voice_on;
          voice_on = 1'b0;
        end
        default: begin
          r.mix_l = it.mix_l;
          r.mix_r = it.mix_r;
          if (voice_on) begin
            ipos = longint'(position[POS_W-1:16]);
            if (ipos + 1 >= longint'(crop_end) || !it.env_on) begin
              voice_on = 1'b0;
              r.ended  = 1'b1;
            end else begin
              voiced++;
              frac  = longint'(position[15:0]);
              scale = (longint'(it.env_level) * longint'(gain)) >>> 15;
              r.mix_l = clamp_mix(longint'(it.mix_l) + voice_part(1'b0, ipos, frac, scale));
              r.mix_r = clamp_mix(longint'(it.mix_r) +
                                  voice_part(channels >= 2'd2, ipos, frac, scale));
              next_pos = longint'(position) + longint'(step_size);
              if (next_pos > 64'h1_FFFF_FFFF) next_pos = 64'h1_FFFF_FFFF;
              position = next_pos[POS_W-1:0];
            end
          end
        end
      endcase
      r.playing = voice_on;
      if (r.ended) note_ends++;
      return r;
    endfunction

    function void note_item(voice_item_t it);
      expected_mix.push_back(predict_mix(it));
    endfunction

    function void check_result(logic signed [MIX_W-1:0] got_l, logic signed [MIX_W-1:0] got_r,
                               logic got_play, logic got_end);
      mix_result_t want;
      if (expected_mix.size() == 0) begin
        report("result with no transaction waiting");
        return;
      end
      want = expected_mix.pop_front();
      checked++;
      if (got_l !== want.mix_l)
        report($sformatf("result %0d left mix %0d, want %0d", checked, got_l, want.mix_l));
      if (got_r !== want.mix_r)
        report($sformatf("result %0d right mix %0d, want %0d", checked, got_r, want.mix_r));
      if (got_play !== want.playing)
        report($sformatf("result %0d playing %b, want %b", checked, got_play, want.playing));
      if (got_end !== want.ended)
        report($sformatf("result %0d note end %b, want %b", checked, got_end, want.ended));
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [1:0]              cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              in_operation_i;
  logic [15:0]             in_sample_address_i;
  logic                    in_sample_channel_i;
  logic signed [SMP_W-1:0] in_sample_value_i;
  logic [15:0]             in_note_velocity_i;
  logic [STEP_W-1:0]       in_step_ratio_i;
  logic [15:0]             in_envelope_level_i;
  logic                    in_envelope_active_i;
  logic signed [MIX_W-1:0] in_mix_in_left_i;
  logic signed [MIX_W-1:0] in_mix_in_right_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [MIX_W-1:0] out_mix_out_left_o;
  logic signed [MIX_W-1:0] out_mix_out_right_o;
  logic                    out_voice_playing_o;
  logic                    out_note_ended_o;

  voice_mix_scoreboard board;
  int unsigned         cycles = 0;
  int                  stall_left = 0;
  int                  stall_roll;
  int                  sent_items = 0;
  int                  phases = 0;
  bit                  burst = 1'b0;

  sample_voice_linear_resampler DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end
  end

  // receiver back-pressure: short bursts, a few long stalls, some quiet stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 45) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(0, 5);
      end else if (stall_roll < 75) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 3);
      end else if (stall_roll < 92) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(10, 60);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      board.check_result(out_mix_out_left_o, out_mix_out_right_o,
                         out_voice_playing_o, out_note_ended_o);
  end

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic signed [MIX_W-1:0] pick_mix();
    case ($urandom_range(0, 9))
      0: return MIX_MAX - 24'($urandom_range(0, 40000));
      1: return MIX_MIN + 24'($urandom_range(0, 40000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 24'($urandom_range(32'h4000, 32'h20000));
    if (roll < 50) return 24'h010000;
    if (roll < 58) return 24'h000000;
    if (roll < 66) return 24'hFFFFFF;
    return 24'($urandom_range(0, 32'h7FFFF));
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic voice_item_t rand_item(logic [1:0] op);
    voice_item_t it;
    it.op        = op;
    it.addr      = 16'($urandom);
    it.chan      = 1'($urandom);
    it.value     = 16'($urandom);
    it.velocity  = pick_q15();
    it.step      = 24'($urandom);
    it.env_level = pick_q15();
    it.env_on    = 1'($urandom);
    it.mix_l     = pick_mix();
    it.mix_r     = pick_mix();
    return it;
  endfunction

  task automatic send_item(input voice_item_t it);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_operation_i       <= it.op;
    in_sample_address_i  <= it.addr;
    in_sample_channel_i  <= it.chan;
    in_sample_value_i    <= it.value;
    in_note_velocity_i   <= it.velocity;
    in_step_ratio_i      <= it.step;
    in_envelope_level_i  <= it.env_level;
    in_envelope_active_i <= it.env_on;
    in_mix_in_left_i     <= it.mix_l;
    in_mix_in_right_i    <= it.mix_r;
    in_valid_i           <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_item(it);
    sent_items++;
  endtask

  task automatic send_load(input int addr, input bit chan, input logic signed [SMP_W-1:0] value);
    voice_item_t it;
    it       = rand_item(OP_LOAD);
    it.addr  = 16'(addr);
    it.chan  = chan;
    it.value = value;
    send_item(it);
  endtask

  task automatic send_start(input logic [15:0] velocity, input logic [STEP_W-1:0] step);
    voice_item_t it;
    it          = rand_item(OP_START);
    it.velocity = velocity;
    it.step     = step;
    send_item(it);
  endtask

  task automatic send_tick(input logic [15:0] level, input bit active,
                           input logic signed [MIX_W-1:0] left, input logic signed [MIX_W-1:0] right);
    voice_item_t it;
    it           = rand_item(OP_TICK);
    it.env_level = level;
    it.env_on    = active;
    it.mix_l     = left;
    it.mix_r     = right;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    board.note_config(idx, data);
  endtask

  task automatic configure(input logic [15:0] start_idx, input logic [16:0] end_mark,
                           input logic [1:0] chans);
    drain();
    write_reg(CFG_CROP_START, {1'($urandom), start_idx});
    write_reg(CFG_CROP_END, end_mark);
    write_reg(CFG_SRC_CH, {15'($urandom), chans});
    if ($urandom_range(0, 1) == 1) write_reg(CFG_SPARE, 17'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    phases++;
  endtask

  task automatic run_phase();
    logic [15:0] cs;
    logic [16:0] ce;
    int          count;
    int          roll;
    voice_item_t it;
    case ($urandom_range(0, 9))
      0: begin
        cs = 16'hFFFF;
        ce = 17'h10000;
      end
      1: begin
        cs = 16'($urandom);
        ce = '0;
      end
      2: begin
        cs = '0;
        ce = 17'($urandom_range(1, 20));
      end
      3: begin
        cs = 16'($urandom_range(65500, 65535));
        ce = 17'h10000;
      end
      4: begin
        cs = 16'($urandom_range(1000, 65535));
        ce = 17'($urandom_range(0, 999));
      end
      default: begin
        cs = 16'($urandom);
        ce = 17'(cs) + 17'($urandom_range(1, 20));
        if (ce > 17'h10000) ce = 17'h10000;
      end
    endcase
    burst = ($urandom_range(0, 3) == 0);
    configure(cs, ce, 2'($urandom_range(0, 3)));
    send_item(rand_item(OP_STOP));
    // every sample the voice can read in this setting gets written first
    for (int a = int'(cs); a < int'(ce); a++) begin
      send_load(a, 1'b0, pick_sample());
      send_load(a, 1'b1, pick_sample());
    end
    send_start(pick_q15(), pick_step());
    count = $urandom_range(40, 80);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_start(pick_q15(), pick_step());
      end else if (roll < 80) begin
        it = rand_item(OP_TICK);
        it.env_on = ($urandom_range(0, 99) < 94);
        send_item(it);
      end else if (roll < 86) begin
        send_item(rand_item(OP_LOAD));
      end else if (roll < 92) begin
        send_item(rand_item(OP_STOP));
      end else begin
        send_item(rand_item(2'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    int directed_items;
    board = new();
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= '0;
    cfg_data_i           <= '0;
    in_valid_i           <= 1'b0;
    in_operation_i       <= OP_LOAD;
    in_sample_address_i  <= '0;
    in_sample_channel_i  <= 1'b0;
    in_sample_value_i    <= '0;
    in_note_velocity_i   <= '0;
    in_step_ratio_i      <= '0;
    in_envelope_level_i  <= '0;
    in_envelope_active_i <= 1'b0;
    in_mix_in_left_i     <= '0;
    in_mix_in_right_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: crop end zero, so a started voice ends on its first tick
    send_load(0, 1'b0, 16'sh8000);
    send_load(65535, 1'b1, 16'sh7FFF);
    send_load(0, 1'b1, 16'sh7FFF);
    send_load(1, 1'b0, 16'sh7FFF);
    send_load(1, 1'b1, 16'sh8000);
    send_load(2, 1'b0, pick_sample());
    send_load(2, 1'b1, pick_sample());
    send_tick(16'h8000, 1'b1, MIX_MAX, MIX_MIN);
    send_item(rand_item(OP_STOP));
    send_start(16'h8000, 24'hFFFFFF);
    send_tick(16'h8000, 1'b1, pick_mix(), pick_mix());
    send_start(16'h0000, 24'h000000);
    send_item(rand_item(OP_STOP));

    // stereo, short crop: saturating sums, half steps, end of crop
    configure(16'd0, 17'd3, 2'd2);
    send_start(16'h8000, 24'h008000);
    send_tick(16'h8000, 1'b1, MIX_MIN, MIX_MAX);
    send_tick(16'h8000, 1'b1, pick_mix(), pick_mix());
    send_tick(pick_q15(), 1'b1, pick_mix(), pick_mix());
    send_tick(pick_q15(), 1'b1, pick_mix(), pick_mix());
    send_tick(pick_q15(), 1'b1, pick_mix(), pick_mix());
    send_start(16'h4000, 24'h010000);
    send_start(16'h8000, 24'h018000);
    send_tick(16'h8000, 1'b0, pick_mix(), pick_mix());
    directed_items = sent_items;

    while (sent_items - directed_items < RANDOM_ITEMS) run_phase();
    drain();

    $display("summary: %0d transactions in, %0d results checked, %0d register settings",
             sent_items, board.checked, phases);
    $display("summary: %0d voiced ticks, %0d note ends, %0d clamped sums",
             board.voiced, board.note_ends, board.clamped);
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
